// File: rtl/hpt_pkg.sv
// Package for the homogeneous point transform unit.
// Holds field widths, register indexes, reset values and status codes.
// No dependencies.
package hpt_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 24;
    localparam int REG_W     = 48;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W    = 56;
    localparam int DOT_W     = 58;
    localparam int STAT_W    = 2;
    // Divider pipeline: magnitude, overflow check, 32 quotient bits, round, saturate.
    localparam int QBITS     = 32;
    localparam int DIV_LAT   = QBITS + 4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_WZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_01 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_23 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_01 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_23 = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_01 = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_23 = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_01 = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_23 = 8'd7;

    localparam logic [REG_W-1:0] ONE_LOW  = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] ONE_HIGH = 48'h0040_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic [REG_W-1:0]          cfg_word_t;

    // Identity matrix after reset.
    function automatic cfg_word_t reset_value(input logic [CFG_IDX_W-1:0] idx);
        cfg_word_t v;
        v = '0;
        unique case (idx)
            REG_ROW0_01: v = ONE_LOW;
            REG_ROW1_01: v = ONE_HIGH;
            REG_ROW2_23: v = ONE_LOW;
            REG_ROW3_23: v = ONE_HIGH;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/hpt_divider.sv
// Pipelined signed divider: (num * 2^16) / den rounded to nearest, saturated to Q16.16.
// One quotient bit per stage. Depends on hpt_pkg.
module hpt_divider (
    input  logic                        aclk,
    input  logic                        en,
    input  hpt_pkg::dot_t               num,
    input  hpt_pkg::dot_t               den,
    output logic [hpt_pkg::COORD_W-1:0] quo,
    output logic                        sat
);
    import hpt_pkg::*;

    // Magnitude stage.
    logic             a_neg_reg;
    logic [DOT_W-1:0] a_n_reg, a_d_reg;

    // Iteration registers; index 0 is the overflow check stage.
    logic [DOT_W-1:0] it_r_reg   [0:QBITS];
    logic [DOT_W-1:0] it_d_reg   [0:QBITS];
    logic [QBITS-1:0] it_q_reg   [0:QBITS];
    logic [15:0]      it_low_reg [0:QBITS];
    logic             it_neg_reg [0:QBITS];
    logic             it_nz_reg  [0:QBITS];
    logic             it_ovr_reg [0:QBITS];

    logic [DOT_W-1:0] it_r_next  [1:QBITS];
    logic [QBITS-1:0] it_q_next  [1:QBITS];

    // Rounding stage.
    logic [QBITS:0]   rq_reg;
    logic             r_neg_reg, r_nz_reg, r_ovr_reg;

    logic [QBITS:0]   lim;
    logic [QBITS:0]   mag;
    logic             sat_next;
    logic             round_up;
    logic [COORD_W-1:0] quo_next;

    genvar k;
    generate
        for (k = 0; k < QBITS; k++) begin : g_iter
            logic [DOT_W:0] rs;
            logic [DOT_W:0] diff;
            logic           ge;
            if (k < 16) begin : g_bit
                assign rs = {it_r_reg[k], it_low_reg[k][15-k]};
            end else begin : g_zero
                assign rs = {it_r_reg[k], 1'b0};
            end
            assign ge   = rs >= {1'b0, it_d_reg[k]};
            assign diff = rs - {1'b0, it_d_reg[k]};
            assign it_r_next[k+1] = ge ? diff[DOT_W-1:0] : rs[DOT_W-1:0];
            assign it_q_next[k+1] = {it_q_reg[k][QBITS-2:0], ge};
        end
    endgenerate

    assign round_up = {it_r_reg[QBITS], 1'b0} >= {1'b0, it_d_reg[QBITS]};
    assign lim      = r_neg_reg ? {2'b01, {(QBITS-1){1'b0}}} : {2'b00, {(QBITS-1){1'b1}}};
    assign sat_next = r_nz_reg && (r_ovr_reg || (rq_reg > lim));
    assign mag      = sat_next ? lim : rq_reg;
    always_comb begin
        if (!r_nz_reg) begin
            quo_next = '0;
        end else if (r_neg_reg) begin
            quo_next = COORD_W'(~mag[QBITS-1:0] + 1'b1);
        end else begin
            quo_next = mag[QBITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_neg_reg <= num[DOT_W-1] ^ den[DOT_W-1];
            a_n_reg   <= num[DOT_W-1] ? DOT_W'(~num + 1'b1) : num;
            a_d_reg   <= den[DOT_W-1] ? DOT_W'(~den + 1'b1) : den;

            // The quotient fits 32 bits only when n / 2^16 is below d.
            it_r_reg[0]   <= {16'd0, a_n_reg[DOT_W-1:16]};
            it_d_reg[0]   <= a_d_reg;
            it_q_reg[0]   <= '0;
            it_low_reg[0] <= a_n_reg[15:0];
            it_neg_reg[0] <= a_neg_reg;
            it_nz_reg[0]  <= a_n_reg != '0;
            it_ovr_reg[0] <= a_n_reg[DOT_W-1:16] >= a_d_reg;

            for (int i = 1; i <= QBITS; i++) begin
                it_r_reg[i]   <= it_r_next[i];
                it_q_reg[i]   <= it_q_next[i];
                it_d_reg[i]   <= it_d_reg[i-1];
                it_low_reg[i] <= it_low_reg[i-1];
                it_neg_reg[i] <= it_neg_reg[i-1];
                it_nz_reg[i]  <= it_nz_reg[i-1];
                it_ovr_reg[i] <= it_ovr_reg[i-1];
            end

            rq_reg    <= {1'b0, it_q_reg[QBITS]} + (QBITS+1)'(round_up);
            r_neg_reg <= it_neg_reg[QBITS];
            r_nz_reg  <= it_nz_reg[QBITS];
            r_ovr_reg <= it_ovr_reg[QBITS];

            quo <= quo_next;
            sat <= sat_next;
        end
    end

endmodule

// File: rtl/homogeneous_point_transform_unit.sv
// Top level of the homogeneous point transform unit.
// Depends on hpt_pkg and hpt_divider.
//
// This block maps one Q16.16 point (x, y, z) per item through a 4x4 matrix of
// Q10.14 coefficients and divides the first three row results by the fourth
// (w), rounding to nearest and saturating to Q16.16. It accepts one item in
// every clock cycle while the output is not stalled and returns results in
// order: an item passes the multiply, pair-sum and dot-product registers, the
// divider (one quotient bit per stage for 32 bits plus four stages for
// magnitude, overflow check, rounding and saturation), and one output
// register. When the result is not taken, the whole pipeline holds. Status
// reads 1 when w is zero (outputs are zero) and 2 when any coordinate
// saturated. Configuration writes are taken in any cycle and must only be
// made while no item is in flight; indexes above 7 are ignored.
module homogeneous_point_transform_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpt_pkg::REG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hpt_pkg::coord_t               s_in_x,
    input  hpt_pkg::coord_t               s_in_y,
    input  hpt_pkg::coord_t               s_in_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hpt_pkg::coord_t               m_out_x,
    output hpt_pkg::coord_t               m_out_y,
    output hpt_pkg::coord_t               m_out_z,
    output logic [hpt_pkg::STAT_W-1:0]    m_status
);
    import hpt_pkg::*;

    // Coefficient registers, one 48-bit word per configuration index.
    cfg_word_t coef_reg [0:NUM_REGS-1];

    // Pipeline enable: everything moves unless a finished item waits.
    logic en;

    // Stage 1: products. Row r, column c; constant terms are shifted.
    prod_t prod_reg [0:3][0:2];
    dot_t  cterm_reg [0:3];
    logic  vld1_reg;
    // Stage 2: pair sums.
    dot_t  suma_reg [0:3];
    dot_t  sumb_reg [0:3];
    logic  vld2_reg;
    // Stage 3: dot products.
    dot_t  dot_reg [0:3];
    logic  vld3_reg;
    logic  wzero;

    // Control that runs alongside the divider.
    logic  dly_vld_reg [0:DIV_LAT-1];
    logic  dly_wz_reg  [0:DIV_LAT-1];

    logic [COORD_W-1:0] quo [0:2];
    logic               sat [0:2];

    coord_t coord_in [0:2];

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    assign coord_in[0] = s_in_x;
    assign coord_in[1] = s_in_y;
    assign coord_in[2] = s_in_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= reset_value(CFG_IDX_W'(i));
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            coef_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Multiply, then two levels of addition. The coefficient for column c of
    // row r sits in word 2r + c/2, low half for even c.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= PROD_W'(coef_t'(coef_reg[2*r + c/2][24*(c%2) +: COEF_W]))
                                    * PROD_W'(coord_in[c]);
                end
                cterm_reg[r] <= dot_t'(coef_t'(coef_reg[2*r+1][47:24])) <<< 16;
                suma_reg[r]  <= DOT_W'(prod_reg[r][0]) + DOT_W'(prod_reg[r][1]);
                sumb_reg[r]  <= DOT_W'(prod_reg[r][2]) + cterm_reg[r];
                dot_reg[r]   <= suma_reg[r] + sumb_reg[r];
            end
        end
    end

    assign wzero = dot_reg[3] == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                dly_vld_reg[i] <= 1'b0;
                dly_wz_reg[i]  <= 1'b0;
            end
            m_valid <= 1'b0;
        end else if (en) begin
            vld1_reg       <= s_valid;
            vld2_reg       <= vld1_reg;
            vld3_reg       <= vld2_reg;
            dly_vld_reg[0] <= vld3_reg;
            dly_wz_reg[0]  <= wzero;
            for (int i = 1; i < DIV_LAT; i++) begin
                dly_vld_reg[i] <= dly_vld_reg[i-1];
                dly_wz_reg[i]  <= dly_wz_reg[i-1];
            end
            m_valid <= dly_vld_reg[DIV_LAT-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            hpt_divider u_div (
                .aclk (aclk),
                .en   (en),
                .num  (dot_reg[g]),
                .den  (dot_reg[3]),
                .quo  (quo[g]),
                .sat  (sat[g])
            );
        end
    endgenerate

    // Output register; a zero w overrides whatever the dividers produced.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dly_wz_reg[DIV_LAT-1]) begin
                m_out_x  <= '0;
                m_out_y  <= '0;
                m_out_z  <= '0;
                m_status <= STAT_WZERO;
            end else begin
                m_out_x  <= quo[0];
                m_out_y  <= quo[1];
                m_out_z  <= quo[2];
                m_status <= (sat[0] || sat[1] || sat[2]) ? STAT_SAT : STAT_OK;
            end
        end
    end

    // A zero w must never come out with nonzero coordinates.
    a_wzero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_WZERO) |-> (m_out_x == '0 && m_out_y == '0 && m_out_z == '0))
        else $error("w-zero result carries nonzero coordinates");

    // Only the three defined status codes are produced.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_WZERO || m_status == STAT_SAT))
        else $error("undefined status code");

    // A result that is not taken stays valid, with m_out_x and m_status unchanged.
    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_x) && $stable(m_status)))
        else $error("pipeline moved during a stall");

endmodule
